@@ hdl/pmst_pkg.sv @@
// ----------------------------------------------------------------------------
// pmst_pkg
// Shared types and constants of the minimum spanning tree core: request
// payloads of both channels, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package pmst_pkg;

    localparam int VTX_W    = 5;
    localparam int WGT_W    = 8;
    localparam int TOTAL_W  = 13;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 9;
    localparam int VCOUNT_W = 6;
    localparam int LIMIT_W  = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_LIMIT = 1'd1;

    localparam logic [VCOUNT_W-1:0] VERTEX_COUNT_RESET = 6'd32;
    localparam logic [LIMIT_W-1:0]  WEIGHT_LIMIT_RESET = 9'd100;

    typedef struct packed {
        logic [VTX_W-1:0] row;
        logic [VTX_W-1:0] col;
        logic [WGT_W-1:0] weight;
        logic             last_entry;
    } pmst_in_t;

    typedef struct packed {
        logic [VTX_W-1:0]   from_vertex;
        logic [VTX_W-1:0]   to_vertex;
        logic [WGT_W-1:0]   edge_weight;
        logic [TOTAL_W-1:0] total_weight;
        logic               status;
        logic               last_edge;
    } pmst_out_t;

endpackage

@@ hdl/prim_minimum_spanning_tree_core.sv @@
// ----------------------------------------------------------------------------
// prim_minimum_spanning_tree_core
// Loads an adjacency matrix one entry per request and, on the final entry,
// grows a minimum spanning tree from vertex 0 under a small microprogram.
// ----------------------------------------------------------------------------
// Loading accepts one entry request per cycle while the sequencer is idle.
// After the final entry each round scans all n*n matrix words (n = vertex
// count), reading one matrix word a cycle from the store; a whole run holds
// up to n-1 rounds and is stretched by output stalls.
// Reset clears the sequencer, the tree flags, the sums and the output valid;
// the weight store is not cleared and holds nothing defined until written.
module prim_minimum_spanning_tree_core #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pmst_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pmst_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  pmst_pkg::pmst_in_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output pmst_pkg::pmst_out_t                 out_data
);
    import pmst_pkg::*;

    // Vertex index width, width of a count up to MAX_VERTICES, store address.
    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int AW = 2 * VW;

    // ------------------------------------------------------------------------
    // Microprogram.  Every step carries a control word.  The sequencer stays
    // on a step while its hold condition is true; otherwise it takes the jump
    // when the jump condition is true, and falls through to the next step.
    // ------------------------------------------------------------------------
    typedef enum logic [2:0] {
        COND_FALSE,
        COND_TRUE,
        COND_NO_START,
        COND_SHORT,
        COND_SCAN_MORE,
        COND_OUT_BUSY,
        COND_RUN_DONE
    } cond_t;

    typedef struct packed {
        logic        accept;
        logic        clr_run;
        logic        init_round;
        logic        scan;
        logic        emit;
        cond_t       hold;
        cond_t       jump;
        logic [2:0]  target;
    } ctrl_t;

    localparam logic [2:0] STEP_IDLE  = 3'd0;
    localparam logic [2:0] STEP_START = 3'd1;
    localparam logic [2:0] STEP_RINIT = 3'd2;
    localparam logic [2:0] STEP_SCAN  = 3'd3;
    localparam logic [2:0] STEP_DRAIN = 3'd4;
    localparam logic [2:0] STEP_EMIT  = 3'd5;
    localparam logic [2:0] STEP_LOOP  = 3'd6;

    function automatic ctrl_t program_word(input logic [2:0] step);
        ctrl_t w;
        w = '{accept: 1'b0, clr_run: 1'b0, init_round: 1'b0, scan: 1'b0,
              emit: 1'b0, hold: COND_FALSE, jump: COND_TRUE, target: STEP_IDLE};
        unique case (step)
            STEP_IDLE:
            begin
                w.accept = 1'b1;
                w.hold   = COND_NO_START;
                w.jump   = COND_FALSE;
            end
            STEP_START:
            begin
                w.clr_run = 1'b1;
                w.jump    = COND_SHORT;
                w.target  = STEP_IDLE;
            end
            STEP_RINIT:
            begin
                w.init_round = 1'b1;
                w.jump       = COND_FALSE;
            end
            STEP_SCAN:
            begin
                w.scan = 1'b1;
                w.hold = COND_SCAN_MORE;
                w.jump = COND_FALSE;
            end
            STEP_DRAIN:
            begin
                w.jump = COND_FALSE;
            end
            STEP_EMIT:
            begin
                w.emit   = 1'b1;
                w.hold   = COND_OUT_BUSY;
                w.jump   = COND_RUN_DONE;
                w.target = STEP_IDLE;
            end
            STEP_LOOP:
            begin
                w.target = STEP_RINIT;
            end
            default:
            begin
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------------
    logic [2:0]              pc_reg, pc_next;
    logic [VCOUNT_W-1:0]     vertex_count_reg;
    logic [LIMIT_W-1:0]      weight_limit_reg;
    logic [MAX_VERTICES-1:0] in_tree_reg, in_tree_next;
    logic [TOTAL_W-1:0]      sum_reg, sum_next;
    logic [CW-1:0]           round_reg, round_next;
    logic [VW-1:0]           i_reg, i_next;
    logic [VW-1:0]           j_reg, j_next;
    logic                    rd_valid_reg;
    logic [VW-1:0]           rd_i_reg, rd_j_reg;
    logic [WGT_W-1:0]        mem_q_reg;
    logic [LIMIT_W-1:0]      best_reg, best_next;
    logic [VW-1:0]           best_i_reg, best_i_next;
    logic [VW-1:0]           best_j_reg, best_j_next;
    logic                    found_reg, found_next;
    logic                    out_valid_reg, out_valid_next;
    pmst_out_t               out_data_reg, out_data_next;

    // The matrix store: written while loading, read once a cycle while scanning.
    logic [WGT_W-1:0] mem [2**AW];

    ctrl_t         cw;
    logic [CW-1:0] n_eff;
    logic          in_fire;
    logic          wr_in_range;
    logic          out_busy;
    logic          scan_wrap_row;
    logic          scan_at_end;
    logic          run_last;
    logic          emit_fire;
    logic          hold_true;
    logic          jump_true;
    logic          rd_valid_next;
    logic          candidate;

    assign cw        = program_word(pc_reg);
    assign in_ready  = cw.accept;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Vertex counts above the store size are saturated to it.
    assign n_eff = (int'(vertex_count_reg) > MAX_VERTICES) ? CW'(MAX_VERTICES)
                                                           : CW'(vertex_count_reg);

    assign wr_in_range = (int'(in_data.row) < MAX_VERTICES)
                      && (int'(in_data.col) < MAX_VERTICES);

    assign out_busy      = out_valid_reg && !out_ready;
    assign scan_wrap_row = (CW'(j_reg) == n_eff - CW'(1));
    assign scan_at_end   = scan_wrap_row && (CW'(i_reg) == n_eff - CW'(1));
    // A run ends on a failed round or on the round that adds the last vertex.
    assign run_last      = !found_reg || (round_reg == n_eff - CW'(2));
    assign emit_fire     = cw.emit && !out_busy;

    function automatic logic cond_eval(input cond_t c, input logic start,
                                       input logic short_run, input logic more,
                                       input logic busy, input logic done);
        logic r;
        r = 1'b0;
        case (c)
            COND_FALSE:     r = 1'b0;
            COND_TRUE:      r = 1'b1;
            COND_NO_START:  r = !start;
            COND_SHORT:     r = short_run;
            COND_SCAN_MORE: r = more;
            COND_OUT_BUSY:  r = busy;
            COND_RUN_DONE:  r = done;
            default:        r = 1'b0;
        endcase
        return r;
    endfunction

    assign hold_true = cond_eval(cw.hold, in_fire && in_data.last_entry,
                                 n_eff < CW'(2), !scan_at_end, out_busy, run_last);
    assign jump_true = cond_eval(cw.jump, in_fire && in_data.last_entry,
                                 n_eff < CW'(2), !scan_at_end, out_busy, run_last);

    // A scanned pair counts only from a tree row into a non-tree column.
    assign rd_valid_next = cw.scan && in_tree_reg[i_reg] && !in_tree_reg[j_reg];
    assign candidate     = rd_valid_reg && (mem_q_reg != '0)
                        && ({1'b0, mem_q_reg} < best_reg);

    always_comb
    begin
        pc_next        = pc_reg;
        in_tree_next   = in_tree_reg;
        sum_next       = sum_reg;
        round_next     = round_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        best_next      = best_reg;
        best_i_next    = best_i_reg;
        best_j_next    = best_j_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        if (hold_true)
        begin
            pc_next = pc_reg;
        end
        else if (jump_true)
        begin
            pc_next = cw.target;
        end
        else
        begin
            pc_next = pc_reg + 3'd1;
        end

        if (cw.clr_run)
        begin
            in_tree_next    = '0;
            in_tree_next[0] = (n_eff >= CW'(2));
            sum_next        = '0;
            round_next      = '0;
        end

        if (cw.init_round)
        begin
            best_next   = weight_limit_reg;
            best_i_next = '0;
            best_j_next = '0;
            found_next  = 1'b0;
            i_next      = '0;
            j_next      = '0;
        end

        if (cw.scan)
        begin
            if (scan_wrap_row)
            begin
                j_next = '0;
                i_next = i_reg + VW'(1);
            end
            else
            begin
                j_next = j_reg + VW'(1);
            end
        end

        // Compare stage, in the cycle after the store read.  Strictly smaller
        // keeps the first of equal weights in scan order.
        if (candidate)
        begin
            best_next   = {1'b0, mem_q_reg};
            best_i_next = rd_i_reg;
            best_j_next = rd_j_reg;
            found_next  = 1'b1;
        end

        if (emit_fire)
        begin
            out_valid_next = 1'b1;
            if (found_reg)
            begin
                in_tree_next[best_j_reg]   = 1'b1;
                sum_next                   = sum_reg + TOTAL_W'(best_reg);
                round_next                 = round_reg + CW'(1);
                out_data_next.from_vertex  = VTX_W'(best_i_reg);
                out_data_next.to_vertex    = VTX_W'(best_j_reg);
                out_data_next.edge_weight  = WGT_W'(best_reg);
                out_data_next.total_weight = sum_reg + TOTAL_W'(best_reg);
                out_data_next.status       = 1'b0;
            end
            else
            begin
                out_data_next.from_vertex  = '0;
                out_data_next.to_vertex    = '0;
                out_data_next.edge_weight  = '0;
                out_data_next.total_weight = sum_reg;
                out_data_next.status       = 1'b1;
            end
            out_data_next.last_edge = run_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg           <= STEP_IDLE;
            vertex_count_reg <= VERTEX_COUNT_RESET;
            weight_limit_reg <= WEIGHT_LIMIT_RESET;
            in_tree_reg      <= '0;
            sum_reg          <= '0;
            round_reg        <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            rd_valid_reg     <= 1'b0;
            found_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            in_tree_reg   <= in_tree_next;
            sum_reg       <= sum_next;
            round_reg     <= round_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            rd_valid_reg  <= rd_valid_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_VERTEX_COUNT: vertex_count_reg <= cfg_data[VCOUNT_W-1:0];
                    CFG_WEIGHT_LIMIT: weight_limit_reg <= cfg_data[LIMIT_W-1:0];
                    default:          vertex_count_reg <= vertex_count_reg;
                endcase
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        best_reg     <= best_next;
        best_i_reg   <= best_i_next;
        best_j_reg   <= best_j_next;
        rd_i_reg     <= i_reg;
        rd_j_reg     <= j_reg;
        out_data_reg <= out_data_next;
    end

    // Weight store: entries outside the store size are dropped.
    always_ff @(posedge clk)
    begin
        if (in_fire && wr_in_range)
        begin
            mem[{VW'(in_data.row), VW'(in_data.col)}] <= in_data.weight;
        end
        mem_q_reg <= mem[{i_reg, j_reg}];
    end

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.status |-> out_data_reg.last_edge)
        else $error("failed round not marked as the final result");

    a_root_in_tree: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg == STEP_SCAN |-> in_tree_reg[0])
        else $error("vertex 0 missing from the tree during a scan");

    a_best_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg && (pc_reg == STEP_EMIT) |-> best_reg < weight_limit_reg)
        else $error("chosen weight not below the weight limit");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg == STEP_SCAN |-> (CW'(i_reg) < n_eff) && (CW'(j_reg) < n_eff))
        else $error("scan index beyond the vertex count");

    a_emit_adds_vertex: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire && found_reg |=> $countones(in_tree_reg)
                                   == $countones($past(in_tree_reg)) + 1)
        else $error("emitted edge did not add a new vertex");

endmodule
